### rtl/ecal_pkg.sv
// Shared types, field widths and calendar constants for the epoch-to-calendar converter.
package ecal_pkg;

  // Default width of the seconds counter
  localparam int unsigned ECAL_SECONDS_WIDTH = 32;

  // Result field widths
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned WDAY_W = 3;
  localparam int unsigned YEAR_W = 8;
  localparam int unsigned YDAY_W = 9;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned MDAY_W = 5;

  // Seconds left within one year, within one day and within one hour
  localparam int unsigned YSEC_W = 25;
  localparam int unsigned TOD_W  = 17;
  localparam int unsigned HREM_W = 12;

  // Quotient, product and multiplier operand widths
  localparam int unsigned QUO_W   = 9;
  localparam int unsigned PROD_W  = YSEC_W;
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 19;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Year lengths in seconds for the year walk
  localparam logic [YSEC_W-1:0] SECS_COMMON_YEAR = YSEC_W'(365 * 24 * 60 * 60);
  localparam logic [YSEC_W-1:0] SECS_LEAP_YEAR   = YSEC_W'(366 * 24 * 60 * 60);

  // Divisors applied to the quotients to form the remainders
  localparam logic [MUL_B_W-1:0] SECS_PER_DAY  = MUL_B_W'(24 * 60 * 60);
  localparam logic [MUL_B_W-1:0] SECS_PER_HOUR = MUL_B_W'(60 * 60);
  localparam logic [MUL_B_W-1:0] SECS_PER_MIN  = MUL_B_W'(60);
  localparam logic [MUL_B_W-1:0] DAYS_PER_WEEK = MUL_B_W'(7);

  // Reciprocal division: strip the power of two, then multiply by ceil(2^s / odd part).
  // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15; the error term stays below one step
  // over the dividend ranges reached here.
  localparam int unsigned DAY_PRE  = 7;
  localparam int unsigned HOUR_PRE = 4;
  localparam int unsigned MIN_PRE  = 2;
  localparam logic [MUL_B_W-1:0] DAY_RECIP  = MUL_B_W'(397683);
  localparam logic [MUL_B_W-1:0] HOUR_RECIP = MUL_B_W'(9321);
  localparam logic [MUL_B_W-1:0] MIN_RECIP  = MUL_B_W'(1093);
  localparam logic [MUL_B_W-1:0] WEEK_RECIP = MUL_B_W'(586);
  localparam int unsigned DAY_RECIP_SHIFT  = 28;
  localparam int unsigned HOUR_RECIP_SHIFT = 21;
  localparam int unsigned MIN_RECIP_SHIFT  = 14;
  localparam int unsigned WEEK_RECIP_SHIFT = 12;

  // Epoch and year bookkeeping
  localparam logic [1:0]        EPOCH_MOD4    = 2'd2;     // 1970 mod 4
  localparam logic [6:0]        EPOCH_MOD100  = 7'd70;    // 1970 mod 100
  localparam logic [8:0]        EPOCH_MOD400  = 9'd370;   // 1970 mod 400
  localparam logic [YEAR_W-1:0] EPOCH_YOFF    = 8'd70;    // 1970 - 1900
  localparam logic [YDAY_W-1:0] DAYS_COMMON   = 9'd365;
  localparam logic [YDAY_W-1:0] LAST_FEB_DAY  = 9'd58;    // 28 February, day of year
  localparam logic [YDAY_W-1:0] LEAP_DAY      = 9'd59;    // 29 February in a leap year
  localparam logic [2:0]        EPOCH_WDAY    = 3'd4;     // 1970-01-01 was a Thursday
  localparam logic [WDAY_W:0]   WEEK_LEN      = 4'd7;
  localparam logic [MON_W-1:0]  LAST_MONTH    = 4'd11;

  // Year tracker control
  typedef struct packed {
    logic init;
    logic step;
  } ecal_year_ctrl_t;

  // Year tracker status
  typedef struct packed {
    logic              leap;
    logic [YEAR_W-1:0] year_off;
  } ecal_year_stat_t;

  // Cumulative day count at the start of each month of a common year
  function automatic logic [YDAY_W-1:0] month_start(input logic [MON_W-1:0] m);
    logic [YDAY_W-1:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/ecal_sub_unit.sv
// Shared subtract-and-compare unit used by the year walk, the remainders, the leap fold and the month search.
module ecal_sub_unit #(
  parameter int unsigned Width = 18
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] diff_o,
  output logic             borrow_o
);

  logic [Width:0] full;

  // Subtract with one extra bit to expose the borrow (a < b)
  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[Width-1:0];
  assign borrow_o = full[Width];

endmodule

### rtl/ecal_year_tracker.sv
// Year counter with running residues for the Gregorian leap-year rule.
module ecal_year_tracker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ecal_pkg::ecal_year_ctrl_t ctrl_i,
  output ecal_pkg::ecal_year_stat_t stat_o
);
  import ecal_pkg::*;

  logic [1:0]        mod4_q, mod4_d;
  logic [6:0]        mod100_q, mod100_d;
  logic [8:0]        mod400_q, mod400_d;
  logic [YEAR_W-1:0] yoff_q, yoff_d;

  // Restart at the epoch year or advance by one year
  always_comb begin
    mod4_d   = mod4_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    yoff_d   = yoff_q;
    if (ctrl_i.init) begin
      mod4_d   = EPOCH_MOD4;
      mod100_d = EPOCH_MOD100;
      mod400_d = EPOCH_MOD400;
      yoff_d   = EPOCH_YOFF;
    end else if (ctrl_i.step) begin
      mod4_d   = mod4_q + 2'd1;
      mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
      mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
      yoff_d   = yoff_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod4_q   <= EPOCH_MOD4;
      mod100_q <= EPOCH_MOD100;
      mod400_q <= EPOCH_MOD400;
      yoff_q   <= EPOCH_YOFF;
    end else begin
      mod4_q   <= mod4_d;
      mod100_q <= mod100_d;
      mod400_q <= mod400_d;
      yoff_q   <= yoff_d;
    end
  end

  // Divisible by 4, and not by 100 unless also by 400
  assign stat_o.leap     = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
  assign stat_o.year_off = yoff_q;

endmodule

### rtl/epoch_seconds_to_calendar.sv
// Top level: sequencer that converts epoch seconds to a UTC calendar date and time.
//
//  channel   direction  handshake                  payload
//  epoch     in         epoch_valid_i/epoch_stall_o epoch_seconds_i
//  cal       out        cal_valid_o/cal_stall_i     seconds_o .. day_of_month_o
//
// A transaction walks the years past 1970, runs the day, hour, minute and weekday divisions,
// folds the leap day and searches the month before it reaches the output register.
// The shared subtractor serialises this: one year per cycle, a quotient, product and remainder
// state for each reciprocal division, then the February fold and one month step at a time.
// The input stalls from acceptance until the result moves to the output register.
// A finished result waits in the output register while the next transaction runs.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
module epoch_seconds_to_calendar #(
  parameter int unsigned SECONDS_WIDTH = ecal_pkg::ECAL_SECONDS_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              epoch_valid_i,
  output logic                              epoch_stall_o,
  input  logic [SECONDS_WIDTH-1:0]          epoch_seconds_i,
  output logic                              cal_valid_o,
  input  logic                              cal_stall_i,
  output logic [ecal_pkg::SEC_W-1:0]        seconds_o,
  output logic [ecal_pkg::MIN_W-1:0]        minutes_o,
  output logic [ecal_pkg::HOUR_W-1:0]       hours_o,
  output logic [ecal_pkg::WDAY_W-1:0]       weekday_o,
  output logic [ecal_pkg::YEAR_W-1:0]       years_since_1900_o,
  output logic [ecal_pkg::YDAY_W-1:0]       day_of_year_o,
  output logic [ecal_pkg::MON_W-1:0]        month_o,
  output logic [ecal_pkg::MDAY_W-1:0]       day_of_month_o
);
  import ecal_pkg::*;

  localparam int unsigned SW   = SECONDS_WIDTH;
  localparam int unsigned AluW = SW;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_YEAR  = 3'd1;
  localparam logic [2:0] ST_DIVQ  = 3'd2;
  localparam logic [2:0] ST_DIVP  = 3'd3;
  localparam logic [2:0] ST_DIVR  = 3'd4;
  localparam logic [2:0] ST_LEAP  = 3'd5;
  localparam logic [2:0] ST_MONTH = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Division passes
  localparam logic [1:0] PASS_DAY  = 2'd0;
  localparam logic [1:0] PASS_HOUR = 2'd1;
  localparam logic [1:0] PASS_MIN  = 2'd2;
  localparam logic [1:0] PASS_WEEK = 2'd3;

  logic [2:0]        state_q, state_d;
  logic [1:0]        pass_q, pass_d;
  logic [SW-1:0]     secs_q, secs_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [QUO_W-1:0]  wx_q, wx_d;
  logic [YDAY_W-1:0] days_q, days_d;
  logic [YDAY_W-1:0] yday_q, yday_d;
  logic [MDAY_W-1:0] mday_q, mday_d;
  logic [MON_W-1:0]  mon_q, mon_d;
  logic [HOUR_W-1:0] hour_q, hour_d;
  logic [MIN_W-1:0]  min_q, min_d;
  logic [WDAY_W-1:0] wday_q, wday_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  logic [SEC_W-1:0]  out_sec_q;
  logic [MIN_W-1:0]  out_min_q;
  logic [HOUR_W-1:0] out_hour_q;
  logic [WDAY_W-1:0] out_wday_q;
  logic [YEAR_W-1:0] out_year_q;
  logic [YDAY_W-1:0] out_yday_q;
  logic [MON_W-1:0]  out_mon_q;
  logic [MDAY_W-1:0] out_mday_q;

  logic [AluW-1:0]    alu_a, alu_b, alu_diff;
  logic               alu_borrow;
  logic [MUL_A_W-1:0] mul_a, recip_a;
  logic [MUL_B_W-1:0] mul_b, recip_b, div_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [QUO_W-1:0]   quo_sel;
  logic [WDAY_W:0]    wday_step;
  logic [WDAY_W-1:0]  wday_next;

  ecal_year_ctrl_t   year_ctrl;
  ecal_year_stat_t   year_stat;

  ecal_sub_unit #(
    .Width(AluW)
  ) u_sub (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .diff_o  (alu_diff),
    .borrow_o(alu_borrow)
  );

  ecal_year_tracker u_year (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(year_ctrl),
    .stat_o(year_stat)
  );

  // Advance the January 1 weekday by the length of the year just dropped
  assign wday_step = {1'b0, wday_q} + (year_stat.leap ? 4'd2 : 4'd1);
  assign wday_next = (wday_step >= WEEK_LEN) ? WDAY_W'(wday_step - WEEK_LEN)
                                             : wday_step[WDAY_W-1:0];

  // Pick the reciprocal, divisor and quotient bits of the current division pass
  always_comb begin
    unique case (pass_q)
      PASS_DAY: begin
        recip_a = MUL_A_W'(secs_q[YSEC_W-1:DAY_PRE]);
        recip_b = DAY_RECIP;
        div_b   = SECS_PER_DAY;
        quo_sel = mul_p[DAY_RECIP_SHIFT +: QUO_W];
      end
      PASS_HOUR: begin
        recip_a = MUL_A_W'(secs_q[TOD_W-1:HOUR_PRE]);
        recip_b = HOUR_RECIP;
        div_b   = SECS_PER_HOUR;
        quo_sel = mul_p[HOUR_RECIP_SHIFT +: QUO_W];
      end
      PASS_MIN: begin
        recip_a = MUL_A_W'(secs_q[HREM_W-1:MIN_PRE]);
        recip_b = MIN_RECIP;
        div_b   = SECS_PER_MIN;
        quo_sel = mul_p[MIN_RECIP_SHIFT +: QUO_W];
      end
      default: begin
        recip_a = MUL_A_W'(wx_q);
        recip_b = WEEK_RECIP;
        div_b   = DAYS_PER_WEEK;
        quo_sel = mul_p[WEEK_RECIP_SHIFT +: QUO_W];
      end
    endcase
  end

  // Shared multiplier: reciprocal product first, then quotient times divisor
  assign mul_a = (state_q == ST_DIVQ) ? recip_a : MUL_A_W'(quo_q);
  assign mul_b = (state_q == ST_DIVQ) ? recip_b : div_b;
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Steer the shared subtractor
  always_comb begin
    unique case (state_q)
      ST_YEAR: begin
        alu_a = AluW'(secs_q);
        alu_b = AluW'(year_stat.leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR);
      end
      ST_DIVR: begin
        alu_a = (pass_q == PASS_WEEK) ? AluW'(wx_q) : AluW'(secs_q);
        alu_b = AluW'(prod_q);
      end
      ST_LEAP: begin
        alu_a = AluW'(days_q);
        alu_b = AluW'(1);
      end
      ST_MONTH: begin
        alu_a = AluW'(days_q);
        alu_b = AluW'(month_start(mon_q));
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !cal_stall_i);

  // Sequence the year walk, the division passes, the leap fold and the month search
  always_comb begin
    state_d        = state_q;
    pass_d         = pass_q;
    secs_d         = secs_q;
    quo_d          = quo_q;
    prod_d         = prod_q;
    wx_d           = wx_q;
    days_d         = days_q;
    yday_d         = yday_q;
    mday_d         = mday_q;
    mon_d          = mon_q;
    hour_d         = hour_q;
    min_d          = min_q;
    wday_d         = wday_q;
    year_ctrl.init = 1'b0;
    year_ctrl.step = 1'b0;

    out_valid_d = out_valid_q && cal_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (epoch_valid_i) begin
          secs_d         = epoch_seconds_i;
          wday_d         = EPOCH_WDAY;
          year_ctrl.init = 1'b1;
          state_d        = ST_YEAR;
        end
      end
      ST_YEAR: begin
        // Drop whole years while the second count covers them
        if (!alu_borrow) begin
          secs_d         = alu_diff[SW-1:0];
          wday_d         = wday_next;
          year_ctrl.step = 1'b1;
        end else begin
          pass_d  = PASS_DAY;
          state_d = ST_DIVQ;
        end
      end
      ST_DIVQ: begin
        // Quotient from the reciprocal product
        quo_d   = quo_sel;
        state_d = ST_DIVP;
      end
      ST_DIVP: begin
        // Quotient times divisor; keep the day, hour and minute quotients as their fields
        prod_d = mul_p[PROD_W-1:0];
        unique case (pass_q)
          PASS_DAY: begin
            yday_d = quo_q;
            days_d = quo_q;
            wx_d   = quo_q + QUO_W'(wday_q);
          end
          PASS_HOUR: begin
            hour_d = quo_q[HOUR_W-1:0];
          end
          PASS_MIN: begin
            min_d = quo_q[MIN_W-1:0];
          end
          default: begin
          end
        endcase
        state_d = ST_DIVR;
      end
      ST_DIVR: begin
        // Remainder on the shared subtractor
        if (pass_q == PASS_WEEK) begin
          wday_d  = alu_diff[WDAY_W-1:0];
          state_d = ST_LEAP;
        end else begin
          secs_d  = alu_diff[SW-1:0];
          pass_d  = pass_q + 2'd1;
          state_d = ST_DIVQ;
        end
      end
      ST_LEAP: begin
        // Fold 29 February and later leap-year days onto the common-year table
        mday_d  = MDAY_W'(1);
        mon_d   = LAST_MONTH;
        if (year_stat.leap && (days_q > LAST_FEB_DAY)) begin
          days_d = alu_diff[YDAY_W-1:0];
          if (days_q == LEAP_DAY) begin
            mday_d = MDAY_W'(2);
          end
        end
        state_d = ST_MONTH;
      end
      ST_MONTH: begin
        // Walk back from December to the first month that starts on or before the day
        if ((mon_q != '0) && alu_borrow) begin
          mon_d = mon_q - MON_W'(1);
        end else begin
          mday_d  = mday_q + alu_diff[MDAY_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pass_q <= pass_d;
    secs_q <= secs_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
    wx_q   <= wx_d;
    days_q <= days_d;
    yday_q <= yday_d;
    mday_q <= mday_d;
    mon_q  <= mon_d;
    hour_q <= hour_d;
    min_q  <= min_d;
    wday_q <= wday_d;
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sec_q  <= secs_q[SEC_W-1:0];
      out_min_q  <= min_q;
      out_hour_q <= hour_q;
      out_wday_q <= wday_q;
      out_year_q <= year_stat.year_off;
      out_yday_q <= yday_q;
      out_mon_q  <= mon_q;
      out_mday_q <= mday_q;
    end
  end

  assign epoch_stall_o      = (state_q != ST_IDLE);
  assign cal_valid_o        = out_valid_q;
  assign seconds_o          = out_sec_q;
  assign minutes_o          = out_min_q;
  assign hours_o            = out_hour_q;
  assign weekday_o          = out_wday_q;
  assign years_since_1900_o = out_year_q;
  assign day_of_year_o      = out_yday_q;
  assign month_o            = out_mon_q;
  assign day_of_month_o     = out_mday_q;

endmodule

### rtl/ecal_checker.sv
// Port-level checks for the epoch-to-calendar converter, bound to the top level.
module ecal_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              epoch_valid_i,
  input logic                              epoch_stall_o,
  input logic                              cal_valid_o,
  input logic                              cal_stall_i,
  input logic [ecal_pkg::SEC_W-1:0]        seconds_o,
  input logic [ecal_pkg::MIN_W-1:0]        minutes_o,
  input logic [ecal_pkg::HOUR_W-1:0]       hours_o,
  input logic [ecal_pkg::WDAY_W-1:0]       weekday_o,
  input logic [ecal_pkg::YEAR_W-1:0]       years_since_1900_o,
  input logic [ecal_pkg::YDAY_W-1:0]       day_of_year_o,
  input logic [ecal_pkg::MON_W-1:0]        month_o,
  input logic [ecal_pkg::MDAY_W-1:0]       day_of_month_o
);
  import ecal_pkg::*;

  logic in_acc;

  assign in_acc = epoch_valid_i && !epoch_stall_o;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_valid_o && cal_stall_i |=> cal_valid_o && $stable(seconds_o) && $stable(minutes_o)
      && $stable(hours_o) && $stable(weekday_o) && $stable(years_since_1900_o)
      && $stable(day_of_year_o) && $stable(month_o) && $stable(day_of_month_o))
    else $error("result changed while stalled");

  // The converter is busy after taking a transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> epoch_stall_o)
    else $error("input not stalled after acceptance");

  // A result never appears in the cycle after acceptance
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cal_valid_o) |-> !$past(in_acc))
    else $error("result appeared too early");

  // Time and date fields stay in their calendar ranges
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_valid_o |-> (seconds_o < 6'd60) && (minutes_o < 6'd60) && (hours_o < 5'd24)
      && (weekday_o < 3'd7) && (month_o <= LAST_MONTH) && (day_of_month_o != '0)
      && (day_of_year_o <= DAYS_COMMON))
    else $error("calendar field out of range");

  // January days agree with the day of year
  a_january: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_valid_o && (month_o == '0) |-> (YDAY_W'(day_of_month_o) == day_of_year_o + 9'd1))
    else $error("January day of month disagrees with day of year");

endmodule

bind epoch_seconds_to_calendar ecal_checker u_ecal_checker (.*);
